>>> sv/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types and codes for the array stack with positional edit: the
// request and response payloads, operation codes and status codes.
// ----------------------------------------------------------------------------
package asp_pkg;

	// Operation codes carried in a request.
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	// Status codes returned in a response.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	// Request payload.
	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
		logic [7:0]         position;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic signed [31:0] removed_value;
		logic [7:0]         entry_count;
		logic [1:0]         status;
	} rsp_t;

endpackage

>>> sv/asp_req_if.sv
// ----------------------------------------------------------------------------
// asp_req_if
// Request channel: valid/ready handshake with a request payload.
// ----------------------------------------------------------------------------
interface asp_req_if;
	logic          valid;
	logic          ready;
	asp_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> sv/asp_rsp_if.sv
// ----------------------------------------------------------------------------
// asp_rsp_if
// Response channel: valid/ready handshake with a response payload.
// ----------------------------------------------------------------------------
interface asp_rsp_if;
	logic          valid;
	logic          ready;
	asp_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> sv/array_stack_with_positional_edit.sv
// ----------------------------------------------------------------------------
// array_stack_with_positional_edit
// Bounded stack of signed 32-bit words with push, pop, insert at a position
// and delete at a position, one response per request.
// ----------------------------------------------------------------------------
// A request that reads the entry store streams N entries through it, where N
// is the number of entries read: one for pop, count - position + 1 for
// insert and delete. Push, and insert just above the top entry, read
// nothing, and a failed request skips the shift. The single read port of
// the entry store sets the pace: entries are streamed through it one per
// cycle, each written back one slot up (insert) or down (delete) as its
// read data returns. A new request is accepted in the cycle after the
// previous one has been handed to the response register, even if that
// response has not yet been taken. No clearing pass runs after reset.
module array_stack_with_positional_edit #(
	parameter int DEPTH = 128
) (
	input  logic clk,
	input  logic arst_n,
	asp_req_if.sink   req,
	asp_rsp_if.source rsp
);
	import asp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DEC   = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]        state_q;
	req_t              req_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     base_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     rem_q;
	logic              up_q;
	logic [31:0]       removed_q;
	logic [1:0]        status_q;
	logic              rv_s1;
	logic [AW-1:0]     ra_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [31:0]       wdata;
	logic              re;
	logic [31:0]       rdata;

	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     base_x;
	logic [1:0]        dec_status;
	logic              shift_end;
	logic              capture;
	logic              out_free;

	asp_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.W    (32)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	// Request checks against the current count, and the lowest slot touched.
	always_comb begin
		cnt_x      = XW'(count_q);
		pos_x      = XW'(req_q.position);
		dec_status = ST_OK;
		base_x     = cnt_x;
		case (req_q.operation)
			OP_PUSH: begin
				if (cnt_x == XW'(DEPTH)) dec_status = ST_FULL;
				base_x = cnt_x;
			end
			OP_POP: begin
				if (cnt_x == '0) dec_status = ST_EMPTY;
				base_x = cnt_x - 1'b1;
			end
			OP_INSERT: begin
				if (cnt_x == XW'(DEPTH)) dec_status = ST_FULL;
				else if (pos_x == '0 || pos_x > cnt_x + 1'b1) dec_status = ST_BADPOS;
				base_x = pos_x - 1'b1;
			end
			default: begin
				if (cnt_x == '0) dec_status = ST_EMPTY;
				else if (pos_x == '0 || pos_x > cnt_x) dec_status = ST_BADPOS;
				base_x = pos_x - 1'b1;
			end
		endcase
	end

	// Store access during the shift: reads stream from ptr_q, and each
	// returned word is written one slot up or down. The write address is
	// always two slots away from the read address issued in the same
	// cycle, so the two ports never touch the same entry at once.
	always_comb begin
		re        = (state_q == S_SHIFT) && (rem_q != '0);
		shift_end = (state_q == S_SHIFT) && (rem_q == '0) && !rv_s1;
		capture   = (state_q == S_SHIFT) && rv_s1 && !up_q &&
		            (ra_s1 == base_q[AW-1:0]);
		we        = 1'b0;
		waddr     = ra_s1;
		wdata     = rdata;
		if (state_q == S_SHIFT && rv_s1) begin
			we    = !capture;
			waddr = up_q ? ra_s1 + 1'b1 : ra_s1 - 1'b1;
		end else if (shift_end && up_q) begin
			we    = 1'b1;
			waddr = base_q[AW-1:0];
			wdata = req_q.value;
		end
	end

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rv_s1   <= 1'b0;
		end else begin
			rv_s1 <= re;
			case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_DEC;
				end
				S_DEC: begin
					if (dec_status != ST_OK) state_q <= S_DONE;
					else state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (shift_end) begin
						count_q <= up_q ? count_q + 1'b1 : count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				default: begin
					if (out_free) state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request latch, shift pointers and result fields.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.payload;
		end
		if (state_q == S_DEC) begin
			status_q  <= dec_status;
			removed_q <= '0;
			base_q    <= CW'(base_x);
			rem_q     <= CW'(cnt_x - base_x);
			up_q      <= (req_q.operation == OP_PUSH) || (req_q.operation == OP_INSERT);
			if ((req_q.operation == OP_PUSH) || (req_q.operation == OP_INSERT)) begin
				ptr_q <= count_q - 1'b1;
			end else begin
				ptr_q <= CW'(base_x);
			end
		end
		if (re) begin
			ra_s1 <= ptr_q[AW-1:0];
			rem_q <= rem_q - 1'b1;
			ptr_q <= up_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
		end
		if (capture) begin
			removed_q <= rdata;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_q.removed_value <= removed_q;
			rsp_q.entry_count   <= 8'(count_q);
			rsp_q.status        <= status_q;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

`ifndef NO_ASSERTIONS
	// The count never exceeds the store depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	// Read and write ports never address the same entry in one cycle.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != ptr_q[AW-1:0]))
		else $error("read and write collide on one entry");

	// An accepted transaction is decoded in the next cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_DEC))
		else $error("accepted transaction not decoded");

	// A failed request reports no removed word.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.status != ST_OK) |-> (rsp.payload.removed_value == '0))
		else $error("failed request returned a word");

	// The count changes only when a shift finishes.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!shift_end |=> $stable(count_q))
		else $error("count changed outside shift completion");
`endif

endmodule

>>> sv/asp_ram.sv
// ----------------------------------------------------------------------------
// asp_ram
// Entry store: one write port and one read port, with registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module asp_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int W     = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the array stack with positional edit against a behavioral stack
// model. A short table of directed requests covers the empty, bad-position
// and extreme-value cases, then random phases grow the stack to full, mix
// all operations, shrink it back to empty and finish with unshaped requests.
// Both channels idle at random, and each response is compared field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
	import asp_pkg::*;

	localparam int STACK_DEPTH   = 128;
	localparam int DIRECTED_ROWS = 24;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 150;
	localparam int REPORT_LIMIT  = 10;

	// One row of the directed table; the response fields apply when fixed is set.
	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] value;
		logic [7:0]  position;
		bit          fixed;
		logic [31:0] removed;
		logic [7:0]  count;
		logic [1:0]  status;
	} plan_row_t;

	logic clk;
	logic arst_n;

	asp_req_if req_ch ();
	asp_rsp_if rsp_ch ();

	array_stack_with_positional_edit #(
		.DEPTH(STACK_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Model of the stack contents and the responses still owed by the block.
	logic signed [31:0] stack_words [STACK_DEPTH];
	int                 stack_fill;
	rsp_t               pending_rsp_q [$];
	int                 error_count;
	bit                 hold_request;
	bit                 no_idle;

	plan_row_t stimulus_plan [DIRECTED_ROWS] = '{
		'{OP_POP,    32'h0000_0000, 8'd0,   1'b1, 32'h0, 8'd0, ST_EMPTY},
		'{OP_DELETE, 32'h0000_0000, 8'd1,   1'b1, 32'h0, 8'd0, ST_EMPTY},
		'{OP_INSERT, 32'h0000_0005, 8'd0,   1'b1, 32'h0, 8'd0, ST_BADPOS},
		'{OP_INSERT, 32'h0000_0005, 8'd2,   1'b1, 32'h0, 8'd0, ST_BADPOS},
		'{OP_PUSH,   32'h7FFF_FFFF, 8'd0,   1'b1, 32'h0, 8'd1, ST_OK},
		'{OP_PUSH,   32'h8000_0000, 8'd255, 1'b1, 32'h0, 8'd2, ST_OK},
		'{OP_PUSH,   32'hFFFF_FFFF, 8'd0,   1'b1, 32'h0, 8'd3, ST_OK},
		'{OP_PUSH,   32'h0000_0000, 8'd0,   1'b1, 32'h0, 8'd4, ST_OK},
		'{OP_INSERT, 32'h5555_5555, 8'd1,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_INSERT, 32'hAAAA_AAAA, 8'd6,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_INSERT, 32'h0000_0001, 8'd8,   1'b1, 32'h0, 8'd6, ST_BADPOS},
		'{OP_INSERT, 32'h0000_0001, 8'd255, 1'b1, 32'h0, 8'd6, ST_BADPOS},
		'{OP_DELETE, 32'h0000_0000, 8'd0,   1'b1, 32'h0, 8'd6, ST_BADPOS},
		'{OP_DELETE, 32'h0000_0000, 8'd7,   1'b1, 32'h0, 8'd6, ST_BADPOS},
		'{OP_DELETE, 32'hFFFF_FFFF, 8'd6,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_DELETE, 32'h0000_0000, 8'd1,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_POP,    32'h1234_5678, 8'd0,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_INSERT, 32'h0000_007B, 8'd3,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_DELETE, 32'h0000_0000, 8'd2,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_POP,    32'h0000_0000, 8'd0,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_POP,    32'h0000_0000, 8'd0,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_POP,    32'h0000_0000, 8'd0,   1'b0, 32'h0, 8'd0, ST_OK},
		'{OP_POP,    32'h0000_0000, 8'd0,   1'b1, 32'h0, 8'd0, ST_EMPTY},
		'{OP_PUSH,   32'hDEAD_BEEF, 8'd255, 1'b0, 32'h0, 8'd0, ST_OK}
	};

	// Clock with a period of 20.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one request to the stack model and returns the response it owes.
	function automatic rsp_t predict_stack(input req_t item);
		rsp_t result;
		int   slot;
		result.removed_value = '0;
		result.status        = ST_OK;
		case (item.operation)
			OP_PUSH: begin
				if (stack_fill >= STACK_DEPTH) begin
					result.status = ST_FULL;
				end else begin
					stack_words[stack_fill] = item.value;
					stack_fill++;
				end
			end
			OP_POP: begin
				if (stack_fill == 0) begin
					result.status = ST_EMPTY;
				end else begin
					stack_fill--;
					result.removed_value = stack_words[stack_fill];
				end
			end
			OP_INSERT: begin
				if (stack_fill >= STACK_DEPTH) begin
					result.status = ST_FULL;
				end else if (item.position < 1 || item.position > stack_fill + 1) begin
					result.status = ST_BADPOS;
				end else begin
					for (slot = stack_fill; slot > item.position - 1; slot--)
						stack_words[slot] = stack_words[slot - 1];
					stack_words[item.position - 1] = item.value;
					stack_fill++;
				end
			end
			default: begin
				if (stack_fill == 0) begin
					result.status = ST_EMPTY;
				end else if (item.position < 1 || item.position > stack_fill) begin
					result.status = ST_BADPOS;
				end else begin
					result.removed_value = stack_words[item.position - 1];
					for (slot = item.position - 1; slot + 1 < stack_fill; slot++)
						stack_words[slot] = stack_words[slot + 1];
					stack_fill--;
				end
			end
		endcase
		result.entry_count = stack_fill[7:0];
		return result;
	endfunction

	// Idle length: mostly none, some short, a few long.
	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Builds a random request from operation weights; positions are mostly legal.
	function automatic req_t make_request(input int w_push, input int w_pop,
			input int w_insert, input int w_delete);
		req_t item;
		int   roll;
		int   pos_roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			item.value = 32'h8000_0000;
		else if (roll == 1)
			item.value = 32'h7FFF_FFFF;
		else
			item.value = $urandom;
		roll = $urandom_range(0, w_push + w_pop + w_insert + w_delete - 1);
		if (roll < w_push)
			item.operation = OP_PUSH;
		else if (roll < w_push + w_pop)
			item.operation = OP_POP;
		else if (roll < w_push + w_pop + w_insert)
			item.operation = OP_INSERT;
		else
			item.operation = OP_DELETE;
		pos_roll = $urandom_range(0, 9);
		if (item.operation == OP_PUSH || item.operation == OP_POP || pos_roll == 0) begin
			item.position = 8'($urandom_range(0, 255));
		end else if (pos_roll == 1) begin
			// Around the top legal slot, reaching just past the legal range.
			item.position = 8'(stack_fill + $urandom_range(0, 2));
		end else if (item.operation == OP_INSERT) begin
			item.position = 8'($urandom_range(1, stack_fill + 1));
		end else begin
			item.position = (stack_fill == 0) ? 8'd1 : 8'($urandom_range(1, stack_fill));
		end
		return item;
	endfunction

	// Offers one request and records the response owed once it is accepted.
	task automatic offer_request(input req_t item, input bit has_fixed, input rsp_t fixed_rsp);
		int   gap;
		rsp_t predicted;
		gap = idle_cycles();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = predict_stack(item);
		pending_rsp_q.push_back(has_fixed ? fixed_rsp : predicted);
	endtask

	// Stops offering and waits until every owed response has arrived.
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsp_q.size() != 0);
	endtask

	task automatic run_random_phase(input int items, input int w_push, input int w_pop,
			input int w_insert, input int w_delete);
		rsp_t unused_rsp;
		unused_rsp = '0;
		repeat (items)
			offer_request(make_request(w_push, w_pop, w_insert, w_delete), 1'b0, unused_rsp);
	endtask

	// Main stimulus sequence.
	initial begin
		req_t item;
		rsp_t fixed_rsp;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		arst_n         = 1'b0;
		stack_fill     = 0;
		error_count    = 0;
		hold_request   = 1'b0;
		no_idle        = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table.
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			item.operation          = stimulus_plan[row].operation;
			item.value              = stimulus_plan[row].value;
			item.position           = stimulus_plan[row].position;
			fixed_rsp.removed_value = stimulus_plan[row].removed;
			fixed_rsp.entry_count   = stimulus_plan[row].count;
			fixed_rsp.status        = stimulus_plan[row].status;
			offer_request(item, stimulus_plan[row].fixed, fixed_rsp);
		end
		drain_responses();

		// Grow to full while the receiver holds off at the start.
		hold_request = 1'b1;
		run_random_phase(250, 50, 10, 30, 10);
		drain_responses();

		// Balanced mix with no idling on either side.
		no_idle = 1'b1;
		run_random_phase(150, 25, 25, 25, 25);
		drain_responses();
		no_idle = 1'b0;

		// Shrink down to empty and beyond.
		run_random_phase(200, 5, 50, 5, 40);
		drain_responses();

		// Unshaped requests.
		repeat (50) begin
			item.operation = 2'($urandom_range(0, 3));
			item.value     = $urandom;
			item.position  = 8'($urandom_range(0, 255));
			offer_request(item, 1'b0, fixed_rsp);
		end
		drain_responses();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_rsp_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Response receiver: random ready with long hold-offs on request.
	initial begin
		int run_length;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (no_idle) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) != 0) begin
				rsp_ch.ready <= 1'b1;
				run_length = $urandom_range(1, 8);
				repeat (run_length) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b0;
				run_length = 1 + idle_cycles();
				repeat (run_length) @(posedge clk);
			end
		end
	end

	// Compare every accepted response with the oldest owed one.
	always @(posedge clk) begin
		rsp_t owed;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp_q.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("Unexpected response: removed %h count %0d status %0d",
						rsp_ch.payload.removed_value, rsp_ch.payload.entry_count,
						rsp_ch.payload.status);
			end else begin
				owed = pending_rsp_q.pop_front();
				if (rsp_ch.payload.removed_value !== owed.removed_value ||
						rsp_ch.payload.entry_count !== owed.entry_count ||
						rsp_ch.payload.status !== owed.status) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("Mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
							owed.removed_value, owed.entry_count, owed.status,
							rsp_ch.payload.removed_value, rsp_ch.payload.entry_count,
							rsp_ch.payload.status);
				end
			end
		end
	end

	// Watchdog for a hung run.
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> array_stack_with_positional_edit.f
sv/asp_pkg.sv
sv/asp_req_if.sv
sv/asp_rsp_if.sv
sv/asp_ram.sv
sv/array_stack_with_positional_edit.sv
test/testbench.sv
